// ===== rtl/acc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_pkg: shared constants and codes for the accumulator execute unit
// Machine dimensions, and the opcode and register-group codes.
// ----------------------------------------------------------------------------
package acc_pkg;

   // Machine dimensions; the response layout is built around these.
   localparam int MEM_DEPTH = 4096;
   localparam int WORD_BITS = 18;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_SUB  = 5'd1;
   localparam logic [4:0] OP_LDA  = 5'd2;
   localparam logic [4:0] OP_STA  = 5'd3;
   localparam logic [4:0] OP_RLX  = 5'd20;
   localparam logic [4:0] OP_POP  = 5'd21;
   localparam logic [4:0] OP_LDI  = 5'd22;
   localparam logic [4:0] OP_CPI  = 5'd23;
   localparam logic [4:0] OP_SBI  = 5'd24;
   localparam logic [4:0] OP_ADI  = 5'd25;
   localparam logic [4:0] OP_PUSH = 5'd26;
   localparam logic [4:0] OP_RRX  = 5'd27;
   localparam logic [4:0] OP_ASR  = 5'd28;
   localparam logic [4:0] OP_ROL  = 5'd29;
   localparam logic [4:0] OP_ROR  = 5'd30;
   localparam logic [4:0] OP_REG  = 5'd31;

   localparam logic [11:0] GRP_ADDN = 12'd0;
   localparam logic [11:0] GRP_SUBN = 12'd1;
   localparam logic [11:0] GRP_MOV  = 12'd2;
   localparam logic [11:0] GRP_SWAP = 12'd4;
   localparam logic [11:0] GRP_CMP  = 12'd8;
   localparam logic [11:0] GRP_CL   = 12'd16;
   localparam logic [11:0] GRP_CM   = 12'd32;
   localparam logic [11:0] GRP_DIV  = 12'd64;
   localparam logic [11:0] GRP_MUL  = 12'd128;

endpackage

// ===== rtl/acc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acc_divider: restoring divider, one quotient bit per cycle
// The divisor must be nonzero.
// ----------------------------------------------------------------------------
module acc_divider
#(
   parameter int WORD_BITS = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic                 busy,
   output logic                 done,
   output logic [WORD_BITS-1:0] quotient
);

   localparam int CW = $clog2(WORD_BITS + 1);

   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WORD_BITS-1]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(WORD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[WORD_BITS]) begin
            rem_in = {rem_ff[WORD_BITS-2:0], quo_ff[WORD_BITS-1]};
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
         end else begin
            rem_in = trial[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(busy_ff)) else $error("divider done without busy");
   a_no_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff) else $error("divider done while busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
`endif

endmodule

// ===== rtl/accumulator_cpu_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit: execute stage of an accumulator machine
// Runs one instruction per request transfer and reports all registers.
// ----------------------------------------------------------------------------
// Flow: register ops go through S_RD1 and S_EXEC, direct memory ops through
// S_RD1 and S_RD2 (a direct store through S_EXEC), indirect loads and
// arithmetic through S_RD1, S_PTR and S_RD2 (two dependent reads through the
// RAM's registered port), multiply and divide on to S_MUL or S_DIV after S_EXEC.
// One instruction is in flight at a time; req_tready is low meanwhile.
// Reset is synchronous; after reset a clearing pass writes MEM_DEPTH zero
// words, one per cycle, before the first request transfer is taken.
module accumulator_cpu_execute_unit
   import acc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request: [0] indirect, [5:1] mode, [17:6] operand, zero fill to 24 bits.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // Response: [17:0] acc_value, [35:18] b_value, [71:36] product_value,
   // [83:72] stack_value, [84] carry_flag, [85] zero_flag,
   // [86] negative_flag, zero fill to 88 bits.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int W  = WORD_BITS;

   // Sequencer states: one-hot.
   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_RD1   = 9'b000000100,
      S_PTR   = 9'b000001000,
      S_RD2   = 9'b000010000,
      S_EXEC  = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_MUL   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [W-1:0]   acc_ff, acc_in, b_ff, b_in;
   logic [2*W-1:0] prod_ff, prod_in;
   logic [AW-1:0]  sp_ff, sp_in;
   logic           c_ff, c_in, z_ff, z_in, n_ff, n_in;
   logic           ind_ff, ind_in;
   logic [4:0]     mode_ff, mode_in;
   logic [11:0]    opnd_ff, opnd_in;
   logic [AW:0]    clr_ff, clr_in;
   logic           out_v_ff, out_v_in;

   // Single-port RAM, registered read.
   logic [W-1:0]  mem [MEM_DEPTH];
   logic [W-1:0]  rdata_ff;
   logic [AW-1:0] maddr;
   logic [W-1:0]  mwdata;
   logic          mwe;

   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mwdata;
      rdata_ff <= mem[maddr];
   end

   // Divider.
   logic          div_start, div_busy, div_done;
   logic [W-1:0]  div_a, div_b, div_q;

   acc_divider #(.WORD_BITS(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_a), .divisor(div_b),
      .busy(div_busy), .done(div_done), .quotient(div_q)
   );

   logic           is_mem;
   logic [AW-1:0]  dir_addr;
   logic [1:0]     cnt;
   logic [W:0]     sum;
   logic [W-1:0]   imm, rot;

   // Remainder by three: base-4 digits sum to the same residue, then the
   // small sum is brought into range by compare and subtract.
   function automatic logic [1:0] mod3(input logic [11:0] v);
      logic [4:0] s;
      s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) +
          5'(v[9:8]) + 5'(v[11:10]);
      if (s >= 5'd12) s = s - 5'd12;
      if (s >= 5'd6) s = s - 5'd6;
      if (s >= 5'd3) s = s - 5'd3;
      return s[1:0];
   endfunction

   assign dir_addr = AW'(opnd_ff);
   assign imm      = W'(opnd_ff);
   assign cnt      = (opnd_ff > 12'd3) ? mod3(opnd_ff) : opnd_ff[1:0];

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff; b_in = b_ff; prod_in = prod_ff; sp_in = sp_ff;
      c_in = c_ff; z_in = z_ff; n_in = n_ff;
      ind_in = ind_ff; mode_in = mode_ff; opnd_in = opnd_ff;
      clr_in = clr_ff; out_v_in = out_v_ff;
      maddr = dir_addr; mwdata = acc_ff; mwe = 1'b0;
      div_start = 1'b0;
      div_a = acc_ff; div_b = b_ff;
      is_mem = (mode_ff == OP_ADD) || (mode_ff == OP_SUB) ||
               (mode_ff == OP_LDA) || (mode_ff == OP_STA);
      sum = '0; rot = acc_ff;
      case (state_ff)
         S_CLEAR: begin
            maddr = clr_ff[AW-1:0]; mwdata = '0; mwe = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MEM_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               ind_in = req_tdata[0]; mode_in = req_tdata[5:1];
               opnd_in = req_tdata[17:6];
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            // Issue first read: pointer, operand, or stack top for POP.
            maddr = (mode_ff == OP_POP) ? sp_ff : dir_addr;
            if (mode_ff == OP_PUSH) begin
               sp_in = sp_ff - 1'b1;
               state_in = S_EXEC;
            end else if (is_mem && ind_ff) state_in = S_PTR;
            else if (is_mem && mode_ff == OP_STA) state_in = S_EXEC;
            else if (is_mem || mode_ff == OP_POP) state_in = S_RD2;
            else state_in = S_EXEC;
         end
         S_PTR: begin
            maddr = AW'(rdata_ff);
            if (mode_ff == OP_STA) begin
               mwe = 1'b1;
               state_in = S_OUT; out_v_in = 1'b1;
            end else state_in = S_RD2;
         end
         S_RD2: begin
            // Read data now in rdata_ff; execute.
            state_in = S_OUT; out_v_in = 1'b1;
            case (mode_ff)
               OP_ADD: begin
                  sum = {1'b0, acc_ff} + {1'b0, rdata_ff};
                  c_in = sum[W]; z_in = (sum == '0); n_in = 1'b0;
                  acc_in = sum[W-1:0];
               end
               OP_SUB: begin
                  c_in = 1'b0; n_in = acc_ff < rdata_ff; z_in = acc_ff == rdata_ff;
                  acc_in = acc_ff - rdata_ff;
               end
               OP_LDA: begin
                  acc_in = rdata_ff;
                  if (rdata_ff == '0) z_in = 1'b1;
               end
               OP_POP: begin
                  acc_in = rdata_ff; z_in = rdata_ff == '0;
                  sp_in = sp_ff + 1'b1;
               end
               default: ;
            endcase
         end
         S_EXEC: begin
            state_in = S_OUT; out_v_in = 1'b1;
            case (mode_ff)
               OP_STA: mwe = 1'b1;
               OP_PUSH: begin
                  maddr = sp_ff; mwdata = imm; mwe = 1'b1;
               end
               OP_ROR, OP_ROL, OP_ASR: begin
                  case (cnt)
                     2'd1: rot = (mode_ff == OP_ROR) ? {acc_ff[0], acc_ff[W-1:1]} :
                                 (mode_ff == OP_ROL) ? {acc_ff[W-2:0], acc_ff[W-1]} :
                                 {acc_ff[W-1], acc_ff[W-1:1]};
                     2'd2: rot = (mode_ff == OP_ROR) ? {acc_ff[1:0], acc_ff[W-1:2]} :
                                 (mode_ff == OP_ROL) ? {acc_ff[W-3:0], acc_ff[W-1:W-2]} :
                                 {{2{acc_ff[W-1]}}, acc_ff[W-1:2]};
                     2'd3: rot = (mode_ff == OP_ROR) ? {acc_ff[2:0], acc_ff[W-1:3]} :
                                 (mode_ff == OP_ROL) ? {acc_ff[W-4:0], acc_ff[W-1:W-3]} :
                                 {{3{acc_ff[W-1]}}, acc_ff[W-1:3]};
                     default: rot = acc_ff;
                  endcase
                  acc_in = rot;
                  if (rot == '0) z_in = 1'b1;
               end
               OP_RRX: begin
                  c_in = acc_ff[0]; acc_in = {c_ff, acc_ff[W-1:1]};
               end
               OP_RLX: begin
                  c_in = acc_ff[W-1]; acc_in = {acc_ff[W-2:0], c_ff};
               end
               OP_ADI: begin
                  sum = {1'b0, acc_ff} + {1'b0, imm};
                  if (sum[W]) c_in = 1'b1;
                  acc_in = sum[W-1:0];
               end
               OP_SBI: begin
                  n_in = acc_ff < imm; z_in = acc_ff == imm; acc_in = acc_ff - imm;
               end
               OP_CPI: begin
                  if (acc_ff < imm) c_in = 1'b1;
                  else if (acc_ff > imm) c_in = 1'b0;
                  z_in = acc_ff == imm;
               end
               OP_LDI: begin
                  acc_in = imm; z_in = imm == '0; n_in = 1'b0;
               end
               OP_REG: begin
                  case (opnd_ff)
                     GRP_ADDN: begin
                        sum = {1'b0, acc_ff} + {1'b0, ind_ff ? b_ff : acc_ff};
                        c_in = sum[W]; z_in = (sum == '0); n_in = 1'b0;
                        acc_in = sum[W-1:0];
                     end
                     GRP_SUBN: begin
                        c_in = 1'b0;
                        if (ind_ff) begin
                           n_in = acc_ff < b_ff; z_in = acc_ff == b_ff;
                           acc_in = acc_ff - b_ff;
                        end else begin
                           n_in = b_ff < acc_ff; z_in = acc_ff == b_ff;
                           acc_in = b_ff - acc_ff;
                        end
                     end
                     GRP_MOV: if (ind_ff) b_in = acc_ff; else acc_in = b_ff;
                     GRP_SWAP: begin
                        acc_in = b_ff; b_in = acc_ff;
                     end
                     GRP_CMP: begin
                        c_in = acc_ff < b_ff; z_in = acc_ff == b_ff;
                     end
                     GRP_CL: begin
                        if (ind_ff) begin
                           b_in = '0; z_in = acc_ff == '0;
                        end else begin
                           acc_in = '0; z_in = 1'b1;
                        end
                     end
                     GRP_CM: begin
                        if (ind_ff) begin
                           b_in = ~b_ff; z_in = acc_ff == '0;
                        end else begin
                           acc_in = ~acc_ff; z_in = acc_ff == '1;
                        end
                     end
                     GRP_DIV: begin
                        out_v_in = 1'b0; state_in = S_DIV; div_start = 1'b1;
                        if (ind_ff) begin
                           div_a = acc_ff; div_b = (b_ff == '0) ? W'(1) : b_ff;
                           if (b_ff == '0) b_in = W'(1);
                        end else begin
                           div_a = b_ff; div_b = (acc_ff == '0) ? W'(1) : acc_ff;
                        end
                     end
                     GRP_MUL: begin
                        out_v_in = 1'b0; state_in = S_MUL;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               acc_in = div_q; state_in = S_OUT; out_v_in = 1'b1;
            end
         end
         S_MUL: begin
            prod_in = acc_ff * (ind_ff ? b_ff : acc_ff);
            c_in = 1'b0; state_in = S_OUT; out_v_in = 1'b1;
         end
         S_OUT: begin
            if (rsp_tready) begin
               out_v_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         acc_ff <= W'(4); b_ff <= W'(8); prod_ff <= '0; sp_ff <= '0;
         c_ff <= 1'b0; z_ff <= 1'b0; n_ff <= 1'b0;
         clr_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in; b_ff <= b_in; prod_ff <= prod_in; sp_ff <= sp_in;
         c_ff <= c_in; z_ff <= z_in; n_ff <= n_in;
         clr_ff <= clr_in; out_v_ff <= out_v_in;
      end
      ind_ff <= ind_in; mode_ff <= mode_in; opnd_ff <= opnd_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, n_ff, z_ff, c_ff, 12'(sp_ff), 36'(prod_ff),
                        18'(b_ff), 18'(acc_ff)};

`ifndef SYNTHESIS
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while a response waits");
   a_out_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == S_OUT) else $error("response outside output state");
   a_div_only: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == S_DIV) else $error("divider busy out of divide");
   a_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> req_tready) else $error("no return to idle");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for accumulator_cpu_execute_unit
// Sends instruction transfers through a queued driver, predicts the register
// file after each one with a behavioral copy of the machine, and compares
// every response transfer with it, both sides idling at random in two of three phases.
// ----------------------------------------------------------------------------
module testbench
   import acc_pkg::*;
();

   localparam int LIMIT_CYCLES = 1500000;

   // One response transfer, split into fields.
   typedef struct packed {
      logic        neg;
      logic        zero;
      logic        carry;
      logic [11:0] sp;
      logic [35:0] prod;
      logic [17:0] b;
      logic [17:0] a;
   } machine_view_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [0] indirect, [5:1] mode, [17:6] operand
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // acc, b, product, sp, carry, zero, negative

   // Predicted machine state.
   logic [17:0] mdl_mem [0:4095];
   logic [17:0] mdl_a, mdl_b;
   logic [35:0] mdl_prod;
   logic [11:0] mdl_sp;
   logic        mdl_c, mdl_z, mdl_n;

   logic [23:0]      pending_instrs [$];
   machine_view_type expected_views [$];
   int  mismatches, cycles, accepted, received;
   int  send_idle_pct, recv_idle_pct;
   bit  hold_sender;

   accumulator_cpu_execute_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [23:0] pack_instr(logic ind, logic [4:0] mode, logic [11:0] opnd);
      return {6'd0, opnd, mode, ind};
   endfunction

   function automatic logic [11:0] eff_address(logic [11:0] opnd, logic ind);
      return ind ? mdl_mem[opnd][11:0] : opnd;
   endfunction

   // Shift counts above three fold to count mod 3.
   function automatic int fold_count(logic [11:0] opnd);
      return int'((opnd > 12'd3) ? opnd % 12'd3 : opnd);
   endfunction

   task automatic enqueue_instr(logic [23:0] word);
      pending_instrs.insert(pending_instrs.size(), word);
   endtask

   task automatic add_words(logic [17:0] x, logic [17:0] y);
      logic [18:0] s;
      s = {1'b0, x} + {1'b0, y};
      mdl_c = s[18];
      mdl_z = (s == 19'd0);
      mdl_n = 1'b0;
      mdl_a = s[17:0];
   endtask

   task automatic sub_words(logic [17:0] x, logic [17:0] y);
      mdl_c = 1'b0;
      mdl_n = (x < y);
      mdl_z = (x == y);
      mdl_a = x - y;
   endtask

   task automatic run_register_op(logic [11:0] sel, logic ind);
      logic [17:0] t;
      case (sel)
         GRP_ADDN: add_words(mdl_a, ind ? mdl_b : mdl_a);
         GRP_SUBN: if (ind) sub_words(mdl_a, mdl_b); else sub_words(mdl_b, mdl_a);
         GRP_MOV:  if (ind) mdl_b = mdl_a; else mdl_a = mdl_b;
         GRP_SWAP: begin
            t = mdl_a;
            mdl_a = mdl_b;
            mdl_b = t;
         end
         GRP_CMP: begin
            mdl_c = (mdl_a < mdl_b);
            mdl_z = (mdl_a == mdl_b);
         end
         GRP_CL: begin
            if (ind) mdl_b = '0; else mdl_a = '0;
            mdl_z = (mdl_a == 18'd0);
         end
         GRP_CM: begin
            if (ind) mdl_b = ~mdl_b; else mdl_a = ~mdl_a;
            mdl_z = (mdl_a == 18'd0);
         end
         GRP_DIV: begin
            // A zero divisor counts as one; with indirect set the one stays in B.
            if (ind) begin
               if (mdl_b == 18'd0) mdl_b = 18'd1;
               mdl_a = mdl_a / mdl_b;
            end else begin
               t = (mdl_a == 18'd0) ? 18'd1 : mdl_a;
               mdl_a = mdl_b / t;
            end
         end
         GRP_MUL: begin
            mdl_prod = 36'(mdl_a) * 36'(ind ? mdl_b : mdl_a);
            mdl_c = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Executes one instruction on the predicted machine and queues the result.
   task automatic execute_instr(logic [23:0] word);
      logic             ind;
      logic [4:0]       mode;
      logic [11:0]      opnd;
      logic [18:0]      s;
      logic             c;
      int               n;
      machine_view_type view;
      ind = word[0];
      mode = word[5:1];
      opnd = word[17:6];
      case (mode)
         OP_ADD: add_words(mdl_a, mdl_mem[eff_address(opnd, ind)]);
         OP_SUB: sub_words(mdl_a, mdl_mem[eff_address(opnd, ind)]);
         OP_LDA: begin
            mdl_a = mdl_mem[eff_address(opnd, ind)];
            if (mdl_a == 18'd0) mdl_z = 1'b1;
         end
         OP_STA: mdl_mem[eff_address(opnd, ind)] = mdl_a;
         OP_ROR: begin
            n = fold_count(opnd);
            for (int i = 0; i < n; i++) mdl_a = {mdl_a[0], mdl_a[17:1]};
            if (mdl_a == 18'd0) mdl_z = 1'b1;
         end
         OP_ROL: begin
            n = fold_count(opnd);
            for (int i = 0; i < n; i++) mdl_a = {mdl_a[16:0], mdl_a[17]};
            if (mdl_a == 18'd0) mdl_z = 1'b1;
         end
         OP_ASR: begin
            n = fold_count(opnd);
            for (int i = 0; i < n; i++) mdl_a = {mdl_a[17], mdl_a[17:1]};
            if (mdl_a == 18'd0) mdl_z = 1'b1;
         end
         OP_RRX: begin
            c = mdl_c;
            mdl_c = mdl_a[0];
            mdl_a = {c, mdl_a[17:1]};
         end
         OP_RLX: begin
            c = mdl_c;
            mdl_c = mdl_a[17];
            mdl_a = {mdl_a[16:0], c};
         end
         OP_PUSH: begin
            mdl_sp = mdl_sp - 12'd1;
            mdl_mem[mdl_sp] = 18'(opnd);
         end
         OP_POP: begin
            mdl_a = mdl_mem[mdl_sp];
            mdl_sp = mdl_sp + 12'd1;
            mdl_z = (mdl_a == 18'd0);
         end
         OP_ADI: begin
            s = {1'b0, mdl_a} + 19'(opnd);
            if (s[18]) mdl_c = 1'b1;
            mdl_a = s[17:0];
         end
         OP_SBI: begin
            mdl_n = (mdl_a < 18'(opnd));
            mdl_z = (mdl_a == 18'(opnd));
            mdl_a = mdl_a - 18'(opnd);
         end
         OP_CPI: begin
            if (mdl_a < 18'(opnd)) mdl_c = 1'b1;
            else if (mdl_a > 18'(opnd)) mdl_c = 1'b0;
            mdl_z = (mdl_a == 18'(opnd));
         end
         OP_LDI: begin
            mdl_a = 18'(opnd);
            mdl_z = (mdl_a == 18'd0);
            mdl_n = 1'b0;
         end
         OP_REG: run_register_op(opnd, ind);
         default: ;
      endcase
      view = '{neg: mdl_n, zero: mdl_z, carry: mdl_c, sp: mdl_sp,
               prod: mdl_prod, b: mdl_b, a: mdl_a};
      expected_views.insert(expected_views.size(), view);
   endtask

   // Picks an opcode from the defined set, with a few unused codes mixed in.
   function automatic logic [4:0] pick_mode();
      case ($urandom_range(0, 15))
         0, 1:   return OP_REG;
         2:      return 5'($urandom_range(4, 19));
         3:      return 5'($urandom_range(OP_RLX, OP_ROR));
         4:      return OP_ADD;
         5:      return OP_SUB;
         6:      return OP_LDA;
         7, 8:   return OP_STA;
         9:      return OP_PUSH;
         10:     return OP_POP;
         11:     return OP_LDI;
         default: return 5'($urandom_range(OP_RLX, OP_ROR));
      endcase
   endfunction

   function automatic logic [11:0] pick_operand(logic [4:0] mode);
      logic [11:0] sels [9] = '{GRP_ADDN, GRP_SUBN, GRP_MOV, GRP_SWAP, GRP_CMP,
                                GRP_CL, GRP_CM, GRP_DIV, GRP_MUL};
      if (mode == OP_REG) begin
         if ($urandom_range(0, 19) == 0) return 12'($urandom);
         return sels[$urandom_range(0, 8)];
      end
      if (mode <= OP_STA) begin
         // A small address pool makes loads hit words that stores wrote.
         if ($urandom_range(0, 3) != 0) return 12'($urandom_range(0, 15));
         return 12'($urandom);
      end
      if (mode >= OP_ASR && $urandom_range(0, 1)) return 12'($urandom_range(0, 7));
      return 12'($urandom);
   endfunction

   // Request driver: pops the queue, idles at random, holds off on request.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) accepted <= accepted + 1;
         if (!hold_sender && pending_instrs.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_instrs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // The prediction follows the instruction order on the request side.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) execute_instr(req_tdata);
   end

   // Response monitor and random back-pressure.
   always @(posedge clock) begin
      machine_view_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         cycles <= cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[86:0];
            received <= received + 1;
            if (expected_views.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected response transfer %h", got);
            end else begin
               want = expected_views.pop_front();
               if (got !== want) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) begin
                     $display("response %0d mismatch: expected a=%h b=%h p=%h sp=%h c%b z%b n%b",
                              received, want.a, want.b, want.prod, want.sp, want.carry,
                              want.zero, want.neg);
                     $display("   got a=%h b=%h p=%h sp=%h c%b z%b n%b",
                              got.a, got.b, got.prod, got.sp, got.carry, got.zero,
                              got.neg);
                  end
               end
            end
         end
      end
   end

   // Watchdog for a hung handshake; it allows for the clearing pass too.
   always @(posedge clock) begin
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d transfers still pending",
                  cycles, expected_views.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_instrs.size() != 0 || req_tvalid || expected_views.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_random(int count);
      logic [4:0] mode;
      for (int i = 0; i < count; i++) begin
         mode = pick_mode();
         enqueue_instr(pack_instr(1'($urandom), mode, pick_operand(mode)));
      end
   endtask

   initial begin
      for (int i = 0; i < 4096; i++) mdl_mem[i] = '0;
      mdl_a = 18'd4;
      mdl_b = 18'd8;
      mdl_prod = '0;
      mdl_sp = '0;
      {mdl_c, mdl_z, mdl_n} = 3'b000;
      mismatches = 0;
      cycles = 0;
      accepted = 0;
      received = 0;
      hold_sender = 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 82;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: operand and data extremes, each opcode but ADD and each group op
      // but MOV, zero divisors, shift counts above three, stack push and pop, indirection.
      enqueue_instr(pack_instr(1'b0, OP_POP, 12'd0));        // stack pointer moves up
      enqueue_instr(pack_instr(1'b0, OP_PUSH, 12'hfff));     // stack pointer moves back down
      enqueue_instr(pack_instr(1'b1, OP_LDI, 12'hfff));
      enqueue_instr(pack_instr(1'b0, OP_STA, 12'hfff));
      enqueue_instr(pack_instr(1'b1, OP_LDA, 12'hfff));      // pointer 4095
      enqueue_instr(pack_instr(1'b0, OP_ROL, 12'hfff));      // count folds
      enqueue_instr(pack_instr(1'b0, OP_REG, GRP_CM));       // complements A
      enqueue_instr(pack_instr(1'b1, OP_REG, GRP_ADDN));     // adds B to A
      enqueue_instr(pack_instr(1'b0, OP_ADI, 12'hfff));
      enqueue_instr(pack_instr(1'b1, OP_REG, GRP_MUL));
      enqueue_instr(pack_instr(1'b0, OP_REG, GRP_MUL));
      enqueue_instr(pack_instr(1'b1, OP_REG, GRP_CL));       // B zero
      enqueue_instr(pack_instr(1'b1, OP_REG, GRP_DIV));      // B zero
      enqueue_instr(pack_instr(1'b0, OP_REG, GRP_CL));       // A zero
      enqueue_instr(pack_instr(1'b0, OP_REG, GRP_DIV));      // A zero
      enqueue_instr(pack_instr(1'b0, OP_SBI, 12'd5));        // negative
      enqueue_instr(pack_instr(1'b0, OP_CPI, 12'hfff));
      enqueue_instr(pack_instr(1'b0, OP_ASR, 12'd3));
      enqueue_instr(pack_instr(1'b0, OP_RRX, 12'd0));
      enqueue_instr(pack_instr(1'b0, OP_RLX, 12'd0));
      enqueue_instr(pack_instr(1'b1, OP_SUB, 12'd0));
      enqueue_instr(pack_instr(1'b1, OP_REG, GRP_SUBN));
      enqueue_instr(pack_instr(1'b0, OP_REG, GRP_CMP));
      enqueue_instr(pack_instr(1'b1, OP_REG, GRP_SWAP));
      enqueue_instr(pack_instr(1'b1, OP_ROR, 12'd4));
      queue_random(600);
      wait_drained();

      // Hold the sender after the block has answered everything, then release it.
      hold_sender = 1'b1;
      repeat (30) @(posedge clock);
      hold_sender = 1'b0;

      send_idle_pct = 82;
      recv_idle_pct = 29;
      queue_random(700);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(700);
      wait_drained();
      repeat (40) @(posedge clock);

      $display("ran %0d instructions over every opcode and register-group select,",
               accepted);
      $display("with random idling on both sides and one full drain of the pipeline.");
      if (mismatches == 0 && expected_views.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== accumulator_cpu_execute_unit.f =====
rtl/acc_pkg.sv
rtl/acc_divider.sv
rtl/accumulator_cpu_execute_unit.sv
sim/testbench.sv
